// ===== src/subrm_pkg.sv =====
// Shared constants and types for the substring removal stream block.
package subrm_pkg;

  localparam int MAX_PATTERN_DEF = 16;
  localparam int CFG_ADDR_W      = 2;
  localparam int CFG_DATA_W      = 64;
  localparam int PLEN_W          = 5;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_PATTERN_LEN  = 2'd0,
    CFG_PATTERN_LOW  = 2'd1,
    CFG_PATTERN_HIGH = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

endpackage

// ===== src/substring_removal_stream.sv =====
// Streaming byte filter that drops every occurrence of a configured pattern.
//
// The block takes one text byte per input beat and removes every
// non-overlapping occurrence of the configured pattern (up to MAX_PATTERN
// bytes), leftmost first; bytes brought together by a removal are not
// searched again. Bytes that may still begin an occurrence stay in a pending
// shift buffer. One decision step per clock, held while it waits on
// out_tready, runs on a single shared prefix comparator: emit the oldest
// held byte, drop a whole occurrence, or stop. An input beat is worked
// through one such step after another, and in_tready is low while a byte
// is in work, so no new byte is taken before the last one is through. On the
// last byte of a string (in_tlast) all held bytes are flushed and the final
// output beat carries out_tlast; if nothing is left, one beat with
// out_tuser low and out_tdata zero marks the end. A pattern length of zero
// passes text through; lengths above MAX_PATTERN act as MAX_PATTERN. Write
// the pattern registers only while the block is idle.
module substring_removal_stream
  import subrm_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] in_char
  input  logic                  in_tlast,   // end_of_string
  // output stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [7:0] out_char
  output logic                  out_tuser,  // [0] has_char
  output logic                  out_tlast   // string_done
);

  localparam int CNT_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = $clog2(MAX_PATTERN);
  localparam int BUF_W = MAX_PATTERN * 8;
  localparam logic [PLEN_W-1:0] LEN_MAX = PLEN_W'(MAX_PATTERN);

  // configuration registers
  logic [PLEN_W-1:0]     pattern_len_r;
  logic [CFG_DATA_W-1:0] pattern_low_r;
  logic [CFG_DATA_W-1:0] pattern_high_r;

  // control state
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               last_r, last_nxt;
  logic               hold_valid_r, hold_valid_nxt;
  logic               out_valid_r, out_valid_nxt;

  // payload
  logic [BUF_W-1:0]   buf_r, buf_nxt;
  logic [7:0]         hold_char_r, hold_char_nxt;
  logic [7:0]         out_char_r, out_char_nxt;
  logic               out_has_r, out_has_nxt;
  logic               out_done_r, out_done_nxt;

  logic [2*CFG_DATA_W-1:0] pat_vec;
  logic [CNT_W-1:0]        len_eff;
  logic [CNT_W-1:0]        cmp_n;
  logic                    prefix_ok;
  logic                    out_free;
  logic                    act_emit, act_drop, act_end;
  logic                    emit_go, end_go;
  logic [CNT_W-1:0]        sh;
  logic [CNT_W+2:0]        sh_bits;

  assign pat_vec  = {pattern_high_r, pattern_low_r};
  assign len_eff  = (pattern_len_r > LEN_MAX) ? CNT_W'(MAX_PATTERN)
                                              : pattern_len_r[CNT_W-1:0];
  assign out_free = !out_valid_r || out_tready;

  // Shared comparator: are the first cmp_n held bytes a pattern prefix?
  assign cmp_n = (count_r >= len_eff) ? len_eff : count_r;

  always_comb begin
    prefix_ok = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((CNT_W'(i) < cmp_n) && (buf_r[i*8 +: 8] != pat_vec[i*8 +: 8])) begin
        prefix_ok = 1'b0;
      end
    end
  end

  // Decide one step of the removal loop. On the last byte of a string a
  // held prefix is flushed instead of waiting for more text.
  always_comb begin
    act_emit = 1'b0;
    act_drop = 1'b0;
    act_end  = 1'b0;
    if (count_r == '0) begin
      act_end = 1'b1;
    end else if (len_eff == '0) begin
      act_emit = 1'b1;
    end else if (count_r >= len_eff) begin
      act_drop = prefix_ok;
      act_emit = !prefix_ok;
    end else if (prefix_ok) begin
      act_emit = last_r;
      act_end  = !last_r;
    end else begin
      act_emit = 1'b1;
    end
  end

  // Within the last byte's work the newest emitted byte waits in the hold
  // register, since only the end of the flush tells whether it closes the
  // string. Otherwise bytes go straight to the output register.
  assign emit_go = (state_r == ST_RUN) && act_emit &&
                   (last_r ? (!hold_valid_r || out_free) : out_free);
  assign end_go  = (state_r == ST_RUN) && act_end && (!last_r || out_free);

  assign sh      = emit_go ? CNT_W'(1) : (((state_r == ST_RUN) && act_drop) ? len_eff : '0);
  assign sh_bits = {sh, 3'b000};

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    last_nxt       = last_r;
    hold_valid_nxt = hold_valid_r;
    hold_char_nxt  = hold_char_r;
    buf_nxt        = buf_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_char_nxt   = out_char_r;
    out_has_nxt    = out_has_r;
    out_done_nxt   = out_done_r;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          // append the new byte behind the held ones
          buf_nxt[8*count_r[IDX_W-1:0] +: 8] = in_tdata;
          count_nxt = count_r + CNT_W'(1);
          last_nxt  = in_tlast;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (emit_go) begin
          if (!last_r) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = buf_r[7:0];
            out_has_nxt   = 1'b1;
            out_done_nxt  = 1'b0;
          end else begin
            if (hold_valid_r) begin
              out_valid_nxt = 1'b1;
              out_char_nxt  = hold_char_r;
              out_has_nxt   = 1'b1;
              out_done_nxt  = 1'b0;
            end
            hold_char_nxt  = buf_r[7:0];
            hold_valid_nxt = 1'b1;
          end
        end
        // advance the buffer past the emitted byte or dropped occurrence
        buf_nxt   = buf_r >> sh_bits;
        count_nxt = count_r - sh;
        if (end_go) begin
          if (last_r) begin
            out_valid_nxt  = 1'b1;
            out_char_nxt   = hold_valid_r ? hold_char_r : 8'h00;
            out_has_nxt    = hold_valid_r;
            out_done_nxt   = 1'b1;
            hold_valid_nxt = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      count_r        <= '0;
      last_r         <= 1'b0;
      hold_valid_r   <= 1'b0;
      out_valid_r    <= 1'b0;
      pattern_len_r  <= '0;
      pattern_low_r  <= '0;
      pattern_high_r <= '0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      last_r       <= last_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_PATTERN_LEN:  pattern_len_r  <= cfg_wdata[PLEN_W-1:0];
          CFG_PATTERN_LOW:  pattern_low_r  <= cfg_wdata;
          CFG_PATTERN_HIGH: pattern_high_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    buf_r       <= buf_nxt;
    hold_char_r <= hold_char_nxt;
    out_char_r  <= out_char_nxt;
    out_has_r   <= out_has_nxt;
    out_done_r  <= out_done_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tuser  = out_has_r;
  assign out_tlast  = out_done_r;

endmodule

// ===== src/subrm_checker.sv =====
// Port-level checks for the substring removal stream, bound to the top level.
module subrm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser,
  input logic       out_tlast
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  // an empty beat only ever marks the end of a string
  a_empty_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && (out_tdata == 8'h00))
    else $error("empty output beat without end mark or with data");

  // taking a byte starts work, so the input side closes next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted back to back");

  // reset leaves the block ready for input with nothing to send
  a_reset: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("block not idle after reset");

endmodule

bind substring_removal_stream subrm_checker u_subrm_checker (.*);
